// File: hdl/pimd_pkg.sv
package pimd_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned OUT_OFFSET  = 1000;
  localparam int unsigned CLAMP_MARGIN = 100;

  // Integral dividend is (|sum| * kp * ts) >> 8; its quotient by ti is capped
  // at 2^DIV_QBITS-1, far beyond any value that survives the output clamp.
  localparam int unsigned DIVIDEND_W = 56;
  localparam int unsigned DIV_QBITS  = 27;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_QBITS);

  localparam logic [DATA_W-1:0] RST_PROP_GAIN     = 16'd256;
  localparam logic [DATA_W-1:0] RST_SAMPLE_TIME   = 16'd1;
  localparam logic [DATA_W-1:0] RST_INTEGRAL_TIME = 16'd1;
  localparam logic [DATA_W-1:0] RST_PWM_PERIOD    = 16'd7200;

  typedef enum logic [1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_SAMPLE_TIME   = 2'd1,
    REG_INTEGRAL_TIME = 2'd2,
    REG_PWM_PERIOD    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] prop_gain;
    logic [DATA_W-1:0] sample_time;
    logic [DATA_W-1:0] integral_time;
    logic [DATA_W-1:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
  } item_t;

  typedef struct packed {
    logic              forward;
    logic [DATA_W-1:0] duty;
  } result_t;

endpackage

// File: hdl/pimd_cfg_regs.sv
module pimd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pimd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pimd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pimd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output pimd_pkg::cfg_t                     cfg
);

  pimd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = pimd_pkg::reg_idx_t'(paddr[pimd_pkg::APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= pimd_pkg::RST_PROP_GAIN;
      cfg.sample_time   <= pimd_pkg::RST_SAMPLE_TIME;
      cfg.integral_time <= pimd_pkg::RST_INTEGRAL_TIME;
      cfg.pwm_period    <= pimd_pkg::RST_PWM_PERIOD;
    end else if (wr_en) begin
      unique case (idx)
        pimd_pkg::REG_PROP_GAIN:     cfg.prop_gain     <= pwdata[pimd_pkg::DATA_W-1:0];
        pimd_pkg::REG_SAMPLE_TIME:   cfg.sample_time   <= pwdata[pimd_pkg::DATA_W-1:0];
        pimd_pkg::REG_INTEGRAL_TIME: cfg.integral_time <= pwdata[pimd_pkg::DATA_W-1:0];
        pimd_pkg::REG_PWM_PERIOD:    cfg.pwm_period    <= pwdata[pimd_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pimd_pkg::REG_PROP_GAIN:     prdata[pimd_pkg::DATA_W-1:0] = cfg.prop_gain;
      pimd_pkg::REG_SAMPLE_TIME:   prdata[pimd_pkg::DATA_W-1:0] = cfg.sample_time;
      pimd_pkg::REG_INTEGRAL_TIME: prdata[pimd_pkg::DATA_W-1:0] = cfg.integral_time;
      pimd_pkg::REG_PWM_PERIOD:    prdata[pimd_pkg::DATA_W-1:0] = cfg.pwm_period;
      default: ;
    endcase
  end

endmodule

// File: hdl/pimd_divider.sv
module pimd_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [pimd_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [pimd_pkg::DATA_W-1:0]         divisor,
  output logic                                done,
  output logic [pimd_pkg::DIV_QBITS-1:0]      quotient
);

  localparam int unsigned QB = pimd_pkg::DIV_QBITS;
  localparam int unsigned DW = pimd_pkg::DATA_W;
  localparam int unsigned HW = pimd_pkg::DIVIDEND_W - QB;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                          state;
  logic [DW-1:0]                    rem;
  logic [pimd_pkg::DIV_CNT_W-1:0]   cnt;
  logic [DW+1:0]                    trial;
  logic                             overflow;

  // Quotient bits shift in at the bottom of the same register that feeds the
  // low dividend bits out at the top.
  assign trial    = {1'b0, rem, quotient[QB-1]} - {2'b00, divisor};
  assign overflow = dividend[pimd_pkg::DIVIDEND_W-1:QB] >= HW'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            if (divisor == '0) begin
              quotient <= '0;
              done     <= 1'b1;
            end else if (overflow) begin
              quotient <= '1;
              done     <= 1'b1;
            end else begin
              rem      <= dividend[QB+DW-1:QB];
              quotient <= dividend[QB-1:0];
              cnt      <= '0;
              state    <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (!trial[DW+1]) begin
            rem <= trial[DW-1:0];
          end else begin
            rem <= {rem[DW-2:0], quotient[QB-1]};
          end
          quotient <= {quotient[QB-2:0], ~trial[DW+1]};
          cnt      <= cnt + 1'b1;
          if (cnt == pimd_pkg::DIV_CNT_W'(QB - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/pi_motor_drive_controller_core.sv
// PI motor drive controller, one channel. Each accepted word carries a
// setpoint and a measured value (signed 16 bit); the block forms the error,
// adds it to a saturating 32-bit error sum, and returns one word with the
// direction flag (forward is set only for a positive output) and the duty,
// the magnitude of kp*err/256 + kp*ts*sum/(ti*256) + 1000 clamped to
// +/-(pwm_period-100), both quotients truncated toward zero. One shared
// 32x32 multiplier runs three products in turn (kp*ts, |sum|*kp*ts,
// |err|*kp) and a radix-2 restoring divider forms the integral quotient.
// A word passes through both and into the output register, once that
// register is free, before the next word can be taken. A zero
// integral time or an integral quotient beyond the divider's 27 bits
// skips the division. A result holds in the output register while the
// next word is accepted. Writes to the APB registers (0 prop_gain,
// 1 sample_time, 2 integral_time, 3 pwm_period, byte addresses 4*i)
// belong between words. An integral time of zero drops the integral
// term.
module pi_motor_drive_controller_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pimd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pimd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pimd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  pimd_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output pimd_pkg::result_t                  result
);

  localparam int unsigned DW = pimd_pkg::DATA_W;
  localparam int unsigned QB = pimd_pkg::DIV_QBITS;
  localparam int unsigned YW = QB + 3;

  typedef enum logic [2:0] {
    S_IDLE, S_GAIN, S_INTEG, S_PROP, S_WAIT, S_SUM, S_EMIT
  } state_t;

  pimd_pkg::cfg_t           cfg;
  state_t                   state;

  logic signed [DW:0]       err;
  logic signed [31:0]       error_sum;
  logic                     err_neg;
  logic                     sum_neg;
  logic [DW:0]              err_mag;
  logic [31:0]              sum_mag;
  logic [63:0]              prod;
  logic signed [YW-1:0]     y;

  logic signed [DW:0]       err_next;
  logic signed [32:0]       sum_wide;
  logic signed [31:0]       error_sum_next;
  logic [31:0]              mul_a;
  logic [31:0]              mul_b;
  logic                     div_start;
  logic                     div_done;
  logic [QB-1:0]            quotient;
  logic signed [YW-1:0]     p_term;
  logic signed [YW-1:0]     i_term;
  logic [DW-1:0]            limit;
  logic signed [YW-1:0]     limit_s;
  logic [YW-1:0]            y_mag;
  pimd_pkg::result_t        result_next;

  pimd_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Integral dividend drops the /256 first: floor(n/(ti*256)) = floor((n>>8)/ti).
  assign div_start = (state == S_PROP);

  pimd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[63:8]),
    .divisor  (cfg.integral_time),
    .done     (div_done),
    .quotient (quotient)
  );

  assign item_ready = (state == S_IDLE);

  // Error and saturating sum update, taken at acceptance.
  always_comb begin
    err_next = {item.setpoint[DW-1], item.setpoint} - {item.measured[DW-1], item.measured};
    sum_wide = {error_sum[31], error_sum} + 33'(err_next);
    if (sum_wide[32] != sum_wide[31]) begin
      error_sum_next = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      error_sum_next = sum_wide[31:0];
    end
  end

  // Shared multiplier operands, one product per state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_GAIN: begin
        mul_a = 32'(cfg.prop_gain);
        mul_b = 32'(cfg.sample_time);
      end
      S_INTEG: begin
        mul_a = sum_mag;
        mul_b = prod[31:0];
      end
      S_PROP: begin
        mul_a = 32'(err_mag);
        mul_b = 32'(cfg.prop_gain);
      end
      default: ;
    endcase
  end

  // Combine terms; prod holds |err|*kp once S_PROP is left.
  always_comb begin
    p_term = YW'(prod[31:8]);
    i_term = YW'(quotient);
    if (err_neg) p_term = -p_term;
    if (sum_neg) i_term = -i_term;
  end

  // Clamp and split into direction and magnitude.
  always_comb begin
    limit   = (cfg.pwm_period > DW'(pimd_pkg::CLAMP_MARGIN))
              ? cfg.pwm_period - DW'(pimd_pkg::CLAMP_MARGIN) : '0;
    limit_s = YW'(limit);
    y_mag   = y[YW-1] ? YW'(-y) : YW'(y);
    if (y > limit_s) begin
      result_next.forward = (limit != '0);
      result_next.duty    = limit;
    end else if (y < -limit_s) begin
      result_next.forward = 1'b0;
      result_next.duty    = limit;
    end else begin
      result_next.forward = (y > 0);
      result_next.duty    = y_mag[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      error_sum    <= '0;
      result_valid <= 1'b0;
    end else begin
      // Drop the held result once taken, unless a new one refills it now.
      if (result_valid && result_ready && (state != S_EMIT)) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            err       <= err_next;
            error_sum <= error_sum_next;
            state     <= S_GAIN;
          end
        end
        S_GAIN: begin
          prod    <= mul_a * mul_b;
          err_neg <= err[DW];
          sum_neg <= error_sum[31];
          err_mag <= err[DW] ? (DW+1)'(-err) : (DW+1)'(err);
          sum_mag <= error_sum[31] ? 32'(-error_sum) : 32'(error_sum);
          state   <= S_INTEG;
        end
        S_INTEG: begin
          prod  <= mul_a * mul_b;
          state <= S_PROP;
        end
        S_PROP: begin
          // Divider latches the integral product at this edge.
          prod  <= mul_a * mul_b;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) state <= S_SUM;
        end
        S_SUM: begin
          y     <= p_term + i_term + YW'(pimd_pkg::OUT_OFFSET);
          state <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output register is free.
          if (!result_valid || result_ready) begin
            result       <= result_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fwd_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.forward |-> result.duty != '0)
    else $error("forward flag with zero duty");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider finished outside wait state");

  a_sum_stable: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !$past(item_valid && item_ready) |-> error_sum == $past(error_sum))
    else $error("error sum changed without an accepted word");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) && !div_done |=> (state == S_WAIT) || (state == S_SUM))
    else $error("sequencer left wait state early");

endmodule

// File: bench/pi_motor_drive_controller_core_test.sv
module pi_motor_drive_controller_core_test;

  // Error-sum bounds, held in 64 bits so the prediction never wraps.
  localparam longint SUM_MAX = 64'sh7fff_ffff;
  localparam longint SUM_MIN = -64'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB side, parked idle from time zero.
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [pimd_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [pimd_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [pimd_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // Word channels.
  logic              item_valid   = 1'b0;
  logic              item_ready;
  pimd_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  pimd_pkg::result_t result;

  always #5 clk = ~clk;

  pi_motor_drive_controller_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Shadow of the register file and of the running error sum.
  pimd_pkg::cfg_t gains = '{prop_gain: pimd_pkg::RST_PROP_GAIN,
                            sample_time: pimd_pkg::RST_SAMPLE_TIME,
                            integral_time: pimd_pkg::RST_INTEGRAL_TIME,
                            pwm_period: pimd_pkg::RST_PWM_PERIOD};
  int   acc_error = 0;

  // Drive commands owed by the block, oldest first.
  pimd_pkg::result_t drive_expected [$];

  int unsigned mismatches   = 0;
  int unsigned idle_pct     = 0;   // chance of a stall burst, per word on input, per check on result side
  bit          backlog_req  = 1'b0;

  // One row of the directed plan: either a register write or a word.
  // Pinned rows carry an expected command that can be read off directly;
  // the rest take the predicted one.
  typedef struct {
    bit                 cfg_row;
    pimd_pkg::reg_idx_t reg_sel;
    logic [15:0]        value;
    pimd_pkg::item_t    word;
    bit                 pinned;
    pimd_pkg::result_t  want;
  } plan_row_t;

  plan_row_t plan [33] = '{
    // Reset gains: kp 1.0, ts/ti 1, clamp 7100, error sum zero.
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd0, 16'sd0}, 1'b1, '{1'b1, 16'd1000}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sh7fff, 16'sh8000}, 1'b1, '{1'b1, 16'd7100}},
    // Sum drops back to zero, so only the proportional term pulls down.
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sh8000, 16'sh7fff}, 1'b1, '{1'b0, 16'd7100}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{-16'sd1000, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    // Zero error against a sum of -1000: output lands exactly on zero -> reverse.
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd5, 16'sd5}, 1'b1, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd1, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd0, 16'sd1}, 1'b0, '{1'b0, 16'd0}},
    // Zero integral time drops the integral term.
    '{1'b1, pimd_pkg::REG_INTEGRAL_TIME, 16'd0, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd100, 16'sd0}, 1'b1, '{1'b1, 16'd1100}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{-16'sd3000, 16'sd0}, 1'b1, '{1'b0, 16'd2000}},
    // Top of every gain register.
    '{1'b1, pimd_pkg::REG_PROP_GAIN, 16'hffff, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b1, pimd_pkg::REG_SAMPLE_TIME, 16'hffff, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b1, pimd_pkg::REG_INTEGRAL_TIME, 16'hffff, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sh8000, 16'sh8000}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sh7fff, 16'sh7fff}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd1, -16'sd1}, 1'b0, '{1'b0, 16'd0}},
    // Zero gain leaves only the offset.
    '{1'b1, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sh8000, 16'sh7fff}, 1'b1, '{1'b1, 16'd1000}},
    // PWM periods of 100 and below clamp everything to zero; 101 leaves a limit of one.
    '{1'b1, pimd_pkg::REG_PWM_PERIOD, 16'd100, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd12, 16'sd3}, 1'b1, '{1'b0, 16'd0}},
    '{1'b1, pimd_pkg::REG_PWM_PERIOD, 16'd0, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sh7fff, 16'sh8000}, 1'b1, '{1'b0, 16'd0}},
    '{1'b1, pimd_pkg::REG_PWM_PERIOD, 16'd101, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd0, 16'sd0}, 1'b1, '{1'b1, 16'd1}},
    '{1'b1, pimd_pkg::REG_PWM_PERIOD, 16'hffff, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{-16'sd7, 16'sd9}, 1'b1, '{1'b1, 16'd1000}},
    // Smallest gain, no integral: check truncation toward zero.
    '{1'b1, pimd_pkg::REG_PROP_GAIN, 16'd1, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b1, pimd_pkg::REG_SAMPLE_TIME, 16'd0, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b1, pimd_pkg::REG_INTEGRAL_TIME, 16'd1, '{16'sd0, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sh8000, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd255, 16'sd0}, 1'b0, '{1'b0, 16'd0}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{-16'sd255, 16'sd0}, 1'b1, '{1'b1, 16'd1000}},
    '{1'b0, pimd_pkg::REG_PROP_GAIN, 16'd0, '{16'sd0, 16'sd257}, 1'b1, '{1'b1, 16'd999}}
  };

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Signed value times an unsigned gain over a positive divisor, truncated
  // toward zero (magnitude first, sign put back afterwards).
  function automatic longint scaled_quotient(input longint a, input bit [63:0] gain,
                                             input bit [63:0] div);
    bit [63:0] mag;
    bit [63:0] q;
    mag = (a < 0) ? -a : a;
    q   = (mag * gain) / div;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Advance the shadow error sum by one control tick and work out the
  // direction and duty that the block should return for it.
  function automatic pimd_pkg::result_t compute_drive(input pimd_pkg::item_t w);
    longint            err;
    longint            total;
    longint            p_term;
    longint            i_term;
    longint            y;
    longint            lim;
    pimd_pkg::result_t r;
    err   = longint'($signed(w.setpoint)) - longint'($signed(w.measured));
    total = longint'(acc_error) + err;
    if (total > SUM_MAX) total = SUM_MAX;
    if (total < SUM_MIN) total = SUM_MIN;
    acc_error = int'(total);

    p_term = scaled_quotient(err, 64'(gains.prop_gain), 64'd256);
    if (gains.integral_time == 16'd0)
      i_term = 0;
    else
      i_term = scaled_quotient(total, 64'(gains.prop_gain) * 64'(gains.sample_time),
                               64'(gains.integral_time) << 8);

    y   = p_term + i_term + longint'(pimd_pkg::OUT_OFFSET);
    lim = (gains.pwm_period > pimd_pkg::CLAMP_MARGIN) ?
          longint'(gains.pwm_period) - longint'(pimd_pkg::CLAMP_MARGIN) : 0;
    if (y > lim)  y = lim;
    if (y < -lim) y = -lim;

    r.forward = (y > 0);
    r.duty    = (y < 0) ? 16'(-y) : 16'(y);
    return r;
  endfunction

  // Offer one word and hold it until the block takes it; then book the
  // expected command and, at random, drop valid for a short burst.
  task automatic send_word(input pimd_pkg::item_t w, input bit pinned,
                           input pimd_pkg::result_t want);
    pimd_pkg::result_t predicted;
    int unsigned       gap;
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predicted = compute_drive(w);
    drive_expected.push_back(pinned ? want : predicted);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      gap = $urandom_range(7, 1);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, drain every owed command, then give the pipeline its latency.
  task automatic settle();
    item_valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // APB write (setup + access) followed by a read-back of the same register.
  // Upper data bits are noise; the registers keep only the low 16.
  task automatic program_reg(input pimd_pkg::reg_idx_t r, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);

    unique case (r)
      pimd_pkg::REG_PROP_GAIN:     gains.prop_gain     = v;
      pimd_pkg::REG_SAMPLE_TIME:   gains.sample_time   = v;
      pimd_pkg::REG_INTEGRAL_TIME: gains.integral_time = v;
      pimd_pkg::REG_PWM_PERIOD:    gains.pwm_period    = v;
      default: ;
    endcase

    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== v)
      report_mismatch($sformatf("register %s read-back", r.name()), v, prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Register value: an extreme, something modest, or anything at all.
  function automatic logic [15:0] pick_setting(input logic [15:0] modest_hi);
    case ($urandom_range(5, 0)) inside
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'd1;
      [3:4]:   return 16'($urandom_range(modest_hi, 0));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(4, 0))
      0:       return 16'($urandom_range(100, 0));
      1:       return 16'd101;
      2:       return 16'hffff;
      3:       return pimd_pkg::RST_PWM_PERIOD;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random control tick: mostly full-range noise or a measured value that
  // tracks the setpoint, with some rail values and zero-error ticks.
  function automatic pimd_pkg::item_t random_word();
    pimd_pkg::item_t w;
    logic [15:0]     rails [4];
    rails = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    case ($urandom_range(9, 0)) inside
      [0:3]: begin
        w.setpoint = 16'($urandom);
        w.measured = 16'($urandom);
      end
      [4:7]: begin
        w.setpoint = 16'($urandom);
        w.measured = w.setpoint + 16'($urandom_range(600, 0) - 300);
      end
      8: begin
        w.setpoint = rails[$urandom_range(3, 0)];
        w.measured = rails[$urandom_range(3, 0)];
      end
      default: begin
        w.setpoint = 16'($urandom);
        w.measured = w.setpoint;
      end
    endcase
    return w;
  endfunction

  // Result side: check every result taken against the oldest owed command,
  // and work result_ready in random stall bursts. One long hold-off, counted
  // here, lets the block back up until it stalls its input.
  initial begin : drain
    int unsigned       hold;
    bit                backlog_taken;
    pimd_pkg::result_t owed;
    hold          = 0;
    backlog_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (drive_expected.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result word: expected none, got forward %0b duty %0d",
                   $time, result.forward, result.duty);
        end else begin
          owed = drive_expected.pop_front();
          if (result.forward !== owed.forward)
            report_mismatch("forward", owed.forward, result.forward);
          if (result.duty !== owed.duty)
            report_mismatch("duty", owed.duty, result.duty);
        end
      end

      if (backlog_req && !backlog_taken) begin
        backlog_taken = 1'b1;
        hold          = 600;
      end

      if (hold != 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        hold = $urandom_range(7, 1) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Input side: reset, directed plan, random phases, then a closing stretch.
  initial begin : stimulus
    int ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed plan; hold register writes until the block is idle.
    idle_pct = 15;
    foreach (plan[k]) begin
      if (plan[k].cfg_row) begin
        settle();
        program_reg(plan[k].reg_sel, plan[k].value);
      end else begin
        send_word(plan[k].word, plan[k].pinned, plan[k].want);
      end
    end
    settle();

    // Random phases, each under fresh register settings and its own idle rate.
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 12;
        default: idle_pct = 35;
      endcase
      // Back up the block once: receiver holds off, sender keeps pushing.
      if (ph == 4) begin
        idle_pct    = 0;
        backlog_req = 1'b1;
      end
      program_reg(pimd_pkg::REG_PROP_GAIN, pick_setting(16'd1024));
      program_reg(pimd_pkg::REG_SAMPLE_TIME, pick_setting(16'd16));
      program_reg(pimd_pkg::REG_INTEGRAL_TIME, pick_setting(16'd4096));
      program_reg(pimd_pkg::REG_PWM_PERIOD, pick_period());
      repeat (140) send_word(random_word(), 1'b0, '0);
      settle();
    end

    // Closing stretch with no idling on either side.
    idle_pct = 0;
    program_reg(pimd_pkg::REG_PROP_GAIN, pick_setting(16'd1024));
    program_reg(pimd_pkg::REG_SAMPLE_TIME, pick_setting(16'd16));
    program_reg(pimd_pkg::REG_INTEGRAL_TIME, pick_setting(16'd4096));
    program_reg(pimd_pkg::REG_PWM_PERIOD, pick_period());
    repeat (100) send_word(random_word(), 1'b0, '0);
    settle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
hdl/pimd_pkg.sv
hdl/pimd_cfg_regs.sv
hdl/pimd_divider.sv
hdl/pi_motor_drive_controller_core.sv
bench/pi_motor_drive_controller_core_test.sv
